FILE: rtl/modular_binomial_table_engine_assert.svh
// assertion helpers shared by the engine modules
`ifndef MODULAR_BINOMIAL_TABLE_ENGINE_ASSERT_SVH
`define MODULAR_BINOMIAL_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// types and constants of the modular binomial table engine
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int TABLE_SIZE = 4096;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int FIELD_W    = 12;
    localparam int VAL_W      = 31;
    localparam int STEP_CNT_W = $clog2(VAL_W);

    localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [1:0] {
        KIND_BUILD = 2'd0,
        KIND_BINOM = 2'd1,
        KIND_MULTI = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] top;
        logic [FIELD_W-1:0] choose;
    } t_item;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_status          status;
    } t_result;

    // one pass of the shift-reduce unit
    typedef struct packed {
        logic [VAL_W-1:0] m;
        logic [VAL_W-1:0] addend;
        logic [VAL_W-1:0] scan;
    } t_step_req;

endpackage

FILE: rtl/mbt_step_unit.sv
// ----------------------------------------------------------------------------
// mbt_step_unit
// shared shift-reduce unit: acc = (2*acc + bit*addend) mod m, msb first
// ----------------------------------------------------------------------------
module mbt_step_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  mbt_pkg::t_step_req       i_req,
    output logic                     o_done,
    output logic [mbt_pkg::VAL_W-1:0] o_rem,
    output logic [mbt_pkg::VAL_W-1:0] o_quo
);
    import mbt_pkg::*;
    `include "modular_binomial_table_engine_assert.svh"

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(VAL_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]      r_acc;
    logic [VAL_W-1:0]      r_quo;
    logic [VAL_W-1:0]      r_scan;
    logic [VAL_W-1:0]      r_m;
    logic [VAL_W-1:0]      r_add;

    logic [VAL_W+1:0] w_sum;
    logic [VAL_W+1:0] w_m1;
    logic [VAL_W+1:0] w_m2;
    logic [VAL_W-1:0] n_acc;
    logic             n_qbit;

    // sum stays below three times m, so one subtraction of m or of 2m reduces it
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0} + (r_scan[VAL_W-1] ? {2'b00, r_add} : '0);
        w_m1  = {2'b00, r_m};
        w_m2  = {1'b0, r_m, 1'b0};
        if (w_sum >= w_m2) begin
            n_acc  = VAL_W'(w_sum - w_m2);
            n_qbit = 1'b1;
        end else if (w_sum >= w_m1) begin
            n_acc  = VAL_W'(w_sum - w_m1);
            n_qbit = 1'b1;
        end else begin
            n_acc  = VAL_W'(w_sum);
            n_qbit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_acc  <= n_acc;
                r_quo  <= {r_quo[VAL_W-2:0], n_qbit};
                r_scan <= {r_scan[VAL_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_quo  <= '0;
                r_scan <= i_req.scan;
                r_m    <= i_req.m;
                r_add  <= i_req.addend;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_acc;
    assign o_quo  = r_quo;

    `MBT_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, i_start, !r_busy, "start while busy")
    `MBT_ASSERT_IMP(a_acc_reduced, i_clk, i_rst_n, r_busy, r_acc < r_m, "accumulator not reduced")
    `MBT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while busy")

endmodule

FILE: rtl/modular_binomial_table_engine.sv
// ----------------------------------------------------------------------------
// modular_binomial_table_engine
// factorial / inverse / inverse-factorial tables mod p, binomial queries
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  item in   start, i_item, busy          taken when start high, busy low
//  result    o_valid, o_result            one cycle, no back-pressure
//  config    i_cfg_we, i_cfg_data         modulus written when we high
//
//  every product, quotient and remainder runs through one shift-reduce unit,
//  one bit a cycle, plus hand-off around each pass
//  query: decode, two table reads, three passes, then the result strobe
//  build: four passes and two table steps (read, launch) per entry; with a
//  modulus below 2 a build is a zero fill of all 4096 entries; the receiver
//  cannot stall, so it never stretches an item
//  reset clears control and loads the default modulus; tables are undefined
//  until the first build, and queries before it report not ready
// ----------------------------------------------------------------------------
module modular_binomial_table_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  mbt_pkg::t_item            i_item,
    output logic                      busy,
    output logic                      o_valid,
    output mbt_pkg::t_result          o_result,
    input  logic                      i_cfg_we,
    input  logic [mbt_pkg::VAL_W-1:0] i_cfg_data
);
    import mbt_pkg::*;
    `include "modular_binomial_table_engine_assert.svh"

    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
    localparam logic [FIELD_W:0]   TOP_LIMIT = (FIELD_W+1)'(TABLE_SIZE);
    localparam logic [VAL_W-1:0]   ONE       = VAL_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLR,
        S_INIT0,
        S_INIT1,
        S_DIV,
        S_RDINV,
        S_LAUNCH_T,
        S_MUL_T,
        S_MUL_F,
        S_MUL_IF,
        S_QRD1,
        S_QRD2,
        S_QRED,
        S_QMUL1,
        S_QMUL2
    } t_state;

    // control state
    t_state           r_state;
    logic             r_ready;
    logic             r_valid;
    logic             r_ustart;
    logic [VAL_W-1:0] r_modulus;

    // payload
    t_item            r_item;
    t_result          r_result;
    t_step_req        r_req;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_rm;
    logic [IDX_W-1:0] r_top;
    logic [IDX_W-1:0] r_r;
    logic [VAL_W-1:0] r_q;
    logic [VAL_W-1:0] r_v;
    logic [VAL_W-1:0] r_fprev;
    logic [VAL_W-1:0] r_ifprev;

    // tables
    logic [VAL_W-1:0] fact_mem [TABLE_SIZE];
    logic [VAL_W-1:0] inv_mem  [TABLE_SIZE];
    logic [VAL_W-1:0] invf_mem [TABLE_SIZE];
    logic [VAL_W-1:0] r_fact_rd;
    logic [VAL_W-1:0] r_inv_rd;
    logic [VAL_W-1:0] r_invf_rd;

    // shared unit
    logic             u_done;
    logic [VAL_W-1:0] u_rem;
    logic [VAL_W-1:0] u_quo;

    mbt_step_unit u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ustart),
        .i_req   (r_req),
        .o_done  (u_done),
        .o_rem   (u_rem),
        .o_quo   (u_quo)
    );

    // query decode
    logic             w_empty;
    logic [FIELD_W:0] w_top;
    logic             w_small_p;

    always_comb begin
        if (r_item.kind == KIND_MULTI) begin
            w_empty = (r_item.top == '0);
            w_top   = {1'b0, r_item.top} + {1'b0, r_item.choose} - 1'b1;
        end else begin
            w_empty = (r_item.choose > r_item.top);
            w_top   = {1'b0, r_item.top};
        end
        w_small_p = (r_modulus < VAL_W'(2));
    end

    // table write and read controls
    logic             w_we_f;
    logic             w_we_i;
    logic             w_we_if;
    logic [IDX_W-1:0] w_waddr;
    logic [VAL_W-1:0] w_wd_f;
    logic [VAL_W-1:0] w_wd_i;
    logic [VAL_W-1:0] w_wd_if;
    logic             w_re_f;
    logic             w_re_i;
    logic             w_re_if;
    logic [IDX_W-1:0] w_raddr_if;

    always_comb begin
        w_we_f     = 1'b0;
        w_we_i     = 1'b0;
        w_we_if    = 1'b0;
        w_waddr    = r_i;
        w_wd_f     = '0;
        w_wd_i     = '0;
        w_wd_if    = '0;
        w_re_f     = (r_state == S_QRD1);
        w_re_i     = (r_state == S_RDINV);
        w_re_if    = (r_state == S_QRD1) || (r_state == S_QRD2);
        w_raddr_if = (r_state == S_QRD1) ? r_r : (r_top - r_r);
        case (r_state)
            S_CLR: begin
                w_we_f  = 1'b1;
                w_we_i  = 1'b1;
                w_we_if = 1'b1;
            end
            S_INIT0: begin
                w_we_f  = 1'b1;
                w_we_i  = 1'b1;
                w_we_if = 1'b1;
                w_waddr = '0;
                w_wd_f  = ONE;
                w_wd_if = ONE;
            end
            S_INIT1: begin
                w_we_f  = 1'b1;
                w_we_i  = 1'b1;
                w_we_if = 1'b1;
                w_waddr = IDX_W'(1);
                w_wd_f  = ONE;
                w_wd_i  = ONE;
                w_wd_if = ONE;
            end
            S_MUL_F: begin
                w_we_f = u_done;
                w_wd_f = u_rem;
            end
            S_MUL_IF: begin
                w_we_i  = u_done;
                w_we_if = u_done;
                w_wd_i  = r_v;
                w_wd_if = u_rem;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_f) begin
            fact_mem[w_waddr] <= w_wd_f;
        end
        if (w_re_f) begin
            r_fact_rd <= fact_mem[r_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_i) begin
            inv_mem[w_waddr] <= w_wd_i;
        end
        if (w_re_i) begin
            r_inv_rd <= inv_mem[r_rm];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_if) begin
            invf_mem[w_waddr] <= w_wd_if;
        end
        if (w_re_if) begin
            r_invf_rd <= invf_mem[w_raddr_if];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ready   <= 1'b0;
            r_valid   <= 1'b0;
            r_ustart  <= 1'b0;
            r_modulus <= MODULUS_RESET;
        end else begin
            r_valid  <= 1'b0;
            r_ustart <= 1'b0;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_result.value <= '0;
                    if (r_item.kind == KIND_BUILD) begin
                        r_result.status <= ST_OK;
                        r_i             <= '0;
                        r_state         <= w_small_p ? S_CLR : S_INIT0;
                    end else if (r_item.kind == KIND_NONE) begin
                        r_result.status <= ST_OK;
                        r_valid         <= 1'b1;
                        r_state         <= S_IDLE;
                    end else if (!r_ready) begin
                        r_result.status <= ST_NOT_READY;
                        r_valid         <= 1'b1;
                        r_state         <= S_IDLE;
                    end else if (w_empty) begin
                        r_result.status <= ST_OK;
                        r_valid         <= 1'b1;
                        r_state         <= S_IDLE;
                    end else if (w_top >= TOP_LIMIT) begin
                        r_result.status <= ST_RANGE;
                        r_valid         <= 1'b1;
                        r_state         <= S_IDLE;
                    end else if (w_small_p) begin
                        r_result.status <= ST_OK;
                        r_valid         <= 1'b1;
                        r_state         <= S_IDLE;
                    end else begin
                        r_result.status <= ST_OK;
                        r_top           <= w_top[IDX_W-1:0];
                        r_r             <= r_item.choose[IDX_W-1:0];
                        r_state         <= S_QRD1;
                    end
                end
                // zero fill for a modulus below 2
                S_CLR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST_IDX) begin
                        r_ready <= 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_INIT0: begin
                    r_state <= S_INIT1;
                end
                S_INIT1: begin
                    r_i      <= IDX_W'(2);
                    r_fprev  <= ONE;
                    r_ifprev <= ONE;
                    r_req    <= '{m: VAL_W'(IDX_W'(2)), addend: ONE, scan: r_modulus};
                    r_ustart <= 1'b1;
                    r_state  <= S_DIV;
                end
                // p div i and p mod i
                S_DIV: begin
                    if (u_done) begin
                        r_q     <= u_quo;
                        r_rm    <= u_rem[IDX_W-1:0];
                        r_state <= S_RDINV;
                    end
                end
                S_RDINV: begin
                    r_state <= S_LAUNCH_T;
                end
                S_LAUNCH_T: begin
                    r_req    <= '{m: r_modulus, addend: r_inv_rd, scan: r_q};
                    r_ustart <= 1'b1;
                    r_state  <= S_MUL_T;
                end
                // recurrence term, negated unless zero
                S_MUL_T: begin
                    if (u_done) begin
                        r_v      <= (u_rem == '0) ? '0 : (r_modulus - u_rem);
                        r_req    <= '{m: r_modulus, addend: r_fprev, scan: VAL_W'(r_i)};
                        r_ustart <= 1'b1;
                        r_state  <= S_MUL_F;
                    end
                end
                S_MUL_F: begin
                    if (u_done) begin
                        r_fprev  <= u_rem;
                        r_req    <= '{m: r_modulus, addend: r_ifprev, scan: r_v};
                        r_ustart <= 1'b1;
                        r_state  <= S_MUL_IF;
                    end
                end
                S_MUL_IF: begin
                    if (u_done) begin
                        r_ifprev <= u_rem;
                        if (r_i == LAST_IDX) begin
                            r_ready <= 1'b1;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_i      <= r_i + 1'b1;
                            r_req    <= '{m: VAL_W'(r_i + 1'b1), addend: ONE,
                                          scan: r_modulus};
                            r_ustart <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end
                end
                // query: fact[n] and invf[r], then invf[n-r]
                S_QRD1: begin
                    r_state <= S_QRD2;
                end
                S_QRD2: begin
                    // invf[r] may exceed a modulus changed since the build
                    r_req    <= '{m: r_modulus, addend: ONE, scan: r_invf_rd};
                    r_ustart <= 1'b1;
                    r_state  <= S_QRED;
                end
                S_QRED: begin
                    if (u_done) begin
                        r_req    <= '{m: r_modulus, addend: u_rem, scan: r_invf_rd};
                        r_ustart <= 1'b1;
                        r_state  <= S_QMUL1;
                    end
                end
                S_QMUL1: begin
                    if (u_done) begin
                        r_req    <= '{m: r_modulus, addend: u_rem, scan: r_fact_rd};
                        r_ustart <= 1'b1;
                        r_state  <= S_QMUL2;
                    end
                end
                S_QMUL2: begin
                    if (u_done) begin
                        r_result.value <= u_rem;
                        r_valid        <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `MBT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "item not taken")
    `MBT_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, r_valid, !busy, "result while busy")
    `MBT_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_valid && r_result.status != ST_OK,
        r_result.value == '0, "error word with nonzero value")
    `MBT_ASSERT_IMP(a_value_reduced, i_clk, i_rst_n,
        r_valid && r_result.value != '0, r_result.value < r_modulus, "value not reduced")

endmodule

FILE: tb/modular_binomial_table_engine_test.sv
// ----------------------------------------------------------------------------
// modular_binomial_table_engine_test
// self-checking bench for the modular binomial table engine
//
// words go in one at a time through start/busy and every accepted word is
// predicted on the spot from a local copy of the modulus and of the three
// tables. Results come back one per word, one cycle wide, and are matched in
// order against the queue of predicted results. Phases cover queries before
// any build, zero-fill builds with a modulus below 2, one full build at the
// largest prime, and queries reduced by other moduli after that build
// ----------------------------------------------------------------------------
module modular_binomial_table_engine_test;

    import mbt_pkg::*;

    // the full build runs long with nothing handed over, so the limit is wide
    localparam int IDLE_LIMIT = 2_000_000;
    localparam int TAIL_WAIT  = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    t_item               i_item = '0;
    logic                busy;
    logic                o_valid;
    t_result             o_result;
    logic                i_cfg_we = 1'b0;
    logic [VAL_W-1:0]    i_cfg_data = '0;

    // local copy of the engine state
    longint unsigned     modulus_copy;
    logic [VAL_W-1:0]    fact_copy     [TABLE_SIZE];
    logic [VAL_W-1:0]    inv_copy      [TABLE_SIZE];
    logic [VAL_W-1:0]    inv_fact_copy [TABLE_SIZE];
    bit                  tables_built;

    t_result             pending_results [$];
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;

    modular_binomial_table_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // rebuild the three tables exactly as a build word does
    function automatic void fill_tables();
        longint unsigned p;
        longint unsigned t;
        longint unsigned v;
        p = modulus_copy;
        tables_built = 1'b1;
        if (p < 2) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                fact_copy[i] = '0;
                inv_copy[i] = '0;
                inv_fact_copy[i] = '0;
            end
            return;
        end
        fact_copy[0] = 1; fact_copy[1] = 1;
        inv_copy[0] = 0;  inv_copy[1] = 1;
        inv_fact_copy[0] = 1; inv_fact_copy[1] = 1;
        for (int i = 2; i < TABLE_SIZE; i++) begin
            // linear inverse recurrence; a zero term stays zero
            t = (longint'(inv_copy[p % i]) * (p / i)) % p;
            v = (t == 0) ? 0 : p - t;
            fact_copy[i] = VAL_W'((longint'(fact_copy[i-1]) * i) % p);
            inv_copy[i] = VAL_W'(v);
            inv_fact_copy[i] = VAL_W'((longint'(inv_fact_copy[i-1]) * v) % p);
        end
    endfunction

    // answer for one word; a build word also updates the tables
    function automatic t_result binomial_answer(t_item w);
        t_result         res;
        int unsigned     n;
        int unsigned     r;
        int unsigned     top_idx;
        bit              empty_choice;
        longint unsigned p;
        longint unsigned inner;
        res.value = '0;
        res.status = ST_OK;
        n = w.top;
        r = w.choose;
        p = modulus_copy;
        if (w.kind == KIND_BUILD) begin
            fill_tables();
        end else if (w.kind == KIND_BINOM || w.kind == KIND_MULTI) begin
            if (!tables_built) begin
                res.status = ST_NOT_READY;
            end else begin
                // multiset with no kinds is an empty choice, checked before range
                empty_choice = (w.kind == KIND_MULTI) ? (n == 0) : (r > n);
                top_idx = (w.kind == KIND_BINOM) ? n : n + r - 1;
                if (empty_choice) begin
                    res.value = '0;
                end else if (top_idx >= TABLE_SIZE) begin
                    res.status = ST_RANGE;
                end else if (p >= 2) begin
                    inner = (longint'(inv_fact_copy[r]) * inv_fact_copy[top_idx - r]) % p;
                    res.value = VAL_W'((longint'(fact_copy[top_idx]) * inner) % p);
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // result checker: every strobed word against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d status %0d",
                                          o_result.value, o_result.status));
            end else begin
                want = pending_results.pop_front();
                if (o_result.value !== want.value)
                    report_mismatch($sformatf("value %0d, predicted %0d",
                                              o_result.value, want.value));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              o_result.status, want.status));
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // drive one word, wait for it to be taken, then an optional gap
    task automatic send_word(input t_kind k, input int unsigned n, input int unsigned r);
        t_item w;
        int    gap;
        w.kind = k;
        w.top = FIELD_W'(n);
        w.choose = FIELD_W'(r);
        start <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(binomial_answer(w));
        // gap 0 keeps start high straight into the next word
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    // modulus write, only while idle
    task automatic set_modulus(input logic [VAL_W-1:0] p);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        modulus_copy = p;
    endtask

    task automatic test_not_ready();
        send_word(KIND_BINOM, 3, 1);
        send_word(KIND_MULTI, 4095, 4095);
        send_word(KIND_NONE, 12, 5);
    endtask

    // zero-fill builds and queries with a modulus below 2
    task automatic test_small_modulus();
        set_modulus(1);
        send_word(KIND_BUILD, 0, 0);
        send_word(KIND_BINOM, 10, 3);
        send_word(KIND_BINOM, 4095, 4095);
        set_modulus(0);
        send_word(KIND_BUILD, 4095, 4095);
        send_word(KIND_MULTI, 7, 2);
        send_word(KIND_BINOM, 2, 9);
    endtask

    // one full build at the largest prime, then field extremes
    task automatic test_full_build();
        set_modulus(31'h7fff_ffff);
        send_word(KIND_BUILD, 1234, 77);
        send_word(KIND_BINOM, 0, 0);
        send_word(KIND_BINOM, 4095, 0);
        send_word(KIND_BINOM, 4095, 4095);
        send_word(KIND_BINOM, 4095, 2048);
        send_word(KIND_BINOM, 5, 7);
        send_word(KIND_MULTI, 0, 5);
        send_word(KIND_MULTI, 0, 0);
        send_word(KIND_MULTI, 4095, 1);
        send_word(KIND_MULTI, 4095, 2);
        send_word(KIND_MULTI, 1, 4095);
        send_word(KIND_MULTI, 2, 4095);
        send_word(KIND_NONE, 4095, 4095);
    endtask

    // random queries; mostly small sizes, some across the whole field
    task automatic test_random_queries(input int count);
        t_kind       k;
        int unsigned n;
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0:       k = KIND_NONE;
                1, 2, 3, 4, 5, 6, 7, 8: k = KIND_MULTI;
                default: k = KIND_BINOM;
            endcase
            case ($urandom_range(0, 5))
                0: begin
                    n = $urandom_range(0, 4095);
                    r = $urandom_range(0, 4095);
                end
                1: begin
                    // near the top of the table
                    n = $urandom_range(3900, 4095);
                    r = $urandom_range(0, 300);
                end
                default: begin
                    n = $urandom_range(0, 60);
                    r = $urandom_range(0, 64);
                end
            endcase
            send_word(k, n, r);
        end
    endtask

    // tables stay, products reduce by whatever modulus is current
    task automatic test_modulus_change();
        set_modulus(31'd1000000007);
        test_random_queries(120);
        set_modulus(2);
        test_random_queries(40);
        set_modulus(31'd65537);
        test_random_queries(40);
        set_modulus(0);
        test_random_queries(20);
    endtask

    initial begin
        modulus_copy = MODULUS_RESET;
        tables_built = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_not_ready();
        test_small_modulus();
        test_full_build();
        test_random_queries(150);
        test_modulus_change();
        drain();

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mbt_pkg.sv
rtl/mbt_step_unit.sv
rtl/modular_binomial_table_engine.sv
tb/modular_binomial_table_engine_test.sv
